### rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// I2C sequencer package
// Shared types, codes and state record for the I2C register transaction
// sequencer and its step logic.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  // Input item function codes.
  localparam logic [2:0] FUNC_POLL  = 3'd0;
  localparam logic [2:0] FUNC_READ  = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_DONE  = 3'd3;
  localparam logic [2:0] FUNC_DIRTY = 3'd4;

  // Completion status codes from the byte engine.
  localparam logic [2:0] DS_OK  = 3'd0;
  localparam logic [2:0] DS_NAK = 3'd1;

  // Result kinds.
  localparam logic [1:0] KIND_ISSUE  = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_IGNORE = 2'd2;

  // Bus primitives.
  localparam logic [2:0] PRIM_RECOVER = 3'd0;
  localparam logic [2:0] PRIM_START   = 3'd1;
  localparam logic [2:0] PRIM_RESTART = 3'd2;
  localparam logic [2:0] PRIM_WRITE   = 3'd3;
  localparam logic [2:0] PRIM_READ    = 3'd4;
  localparam logic [2:0] PRIM_STOP    = 3'd5;

  // Final transaction status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DIRTY    = 3'd1;
  localparam logic [2:0] ST_COMMFAIL = 3'd2;
  localparam logic [2:0] ST_BADADDR  = 3'd3;
  localparam logic [2:0] ST_HWFAIL   = 3'd4;

  // Poll outcome of the address byte, held until the stop completes.
  localparam logic [2:0] POLL_ACK  = 3'd0;
  localparam logic [2:0] POLL_NAK  = 3'd1;
  localparam logic [2:0] POLL_FAIL = 3'd2;

  // Transaction phase.
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RECOVER = 4'd1,
    PH_START   = 4'd2,
    PH_ADDR    = 4'd3,
    PH_REG     = 4'd4,
    PH_RESTART = 4'd5,
    PH_ADDR_RD = 4'd6,
    PH_READ    = 4'd7,
    PH_DATA    = 4'd8,
    PH_STOP    = 4'd9,
    PH_ERRSTOP = 4'd10
  } phase_t;

  // Transaction type.
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  // Sequencer state record.
  typedef struct packed {
    phase_t     phase;
    op_t        operation;
    logic [6:0] saved_device;
    logic [7:0] saved_register;
    logic [7:0] saved_byte;
    logic       bus_dirty;
    logic [2:0] pending;
  } seq_state_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] prim;
    logic [7:0] byte_out;
    logic [2:0] status;
    logic [7:0] read_data;
  } seq_result_t;

endpackage

### rtl/i2c_register_transaction_sequencer.sv
// ----------------------------------------------------------------------------
// I2C register transaction sequencer
// Drives a byte-level I2C engine through poll, register read and register
// write transactions, one primitive at a time.
//
// Usage: every input beat is a command (poll, read, write, mark bus dirty)
// or the completion of the primitive last issued. Every input beat yields
// exactly one result beat: a primitive to issue, a final status, or an
// ignore notice. Both channels use valid and stall.
// A beat accepted at a clock edge is registered at that edge in the input
// register, passes through the step logic, and its result is presented
// from the result register. One beat per cycle is sustained while the
// receiver does not stall; the sequencer state updates with the result.
// When the receiver stalls, the result register holds and the input
// register still takes one further beat before in_stall rises.
// Reset clears both pipeline registers, returns to idle, and sets the
// bus-dirty flag, so the first poll runs bus recovery.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  input  logic [6:0] device_address,
  input  logic [7:0] register_address,
  input  logic [7:0] write_data,
  input  logic [2:0] done_status,
  input  logic [7:0] done_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [2:0] primitive_res,
  output logic [7:0] byte_out,
  output logic [2:0] final_status,
  output logic [7:0] read_data
);
  import i2cseq_pkg::*;

  logic        s1_valid;
  logic        s1_adv;
  logic        in_acc;
  logic [2:0]  s1_func;
  logic [6:0]  s1_device;
  logic [7:0]  s1_register;
  logic [7:0]  s1_wdata;
  logic [2:0]  s1_status;
  logic [7:0]  s1_data;
  seq_state_t  st;
  seq_state_t  st_next;
  seq_result_t rslt_next;
  seq_result_t rslt;

  // Handshake: the input register moves on when the result register is free.
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func     <= func;
      s1_device   <= device_address;
      s1_register <= register_address;
      s1_wdata    <= write_data;
      s1_status   <= done_status;
      s1_data     <= done_data;
    end
  end

  // Transaction step logic.
  i2cseq_step u_step (
    .func             (s1_func),
    .device_address   (s1_device),
    .register_address (s1_register),
    .write_data       (s1_wdata),
    .done_status      (s1_status),
    .done_data        (s1_data),
    .st               (st),
    .st_next          (st_next),
    .rslt             (rslt_next)
  );

  // Sequencer state; the saved transaction fields need no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_IDLE;
      st.operation <= OP_POLL;
      st.bus_dirty <= 1'b1;
      st.pending   <= ST_OK;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rslt <= rslt_next;
    end
  end

  assign result_kind   = rslt.kind;
  assign primitive_res = rslt.prim;
  assign byte_out      = rslt.byte_out;
  assign final_status  = rslt.status;
  assign read_data     = rslt.read_data;

  // An accepted beat always lands in the input register.
  assert property (@(posedge clk) disable iff (rst) in_acc |=> s1_valid)
    else $error("accepted beat not held in input register");

  // A finished transaction leaves the sequencer idle.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && rslt_next.kind == KIND_FINISH |=> st.phase == PH_IDLE)
    else $error("finish result without return to idle");

  // An issued primitive always leaves a transaction in flight.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && rslt_next.kind == KIND_ISSUE |=> st.phase != PH_IDLE)
    else $error("primitive issued while returning to idle");

  // A bus-dirty rejection only happens with the flag set, and it stays set.
  assert property (@(posedge clk) disable iff (rst)
    s1_adv && rslt_next.kind == KIND_FINISH && rslt_next.status == ST_DIRTY
    |=> st.bus_dirty)
    else $error("bus-dirty status with flag clear");

endmodule

### rtl/i2cseq_step.sv
// ----------------------------------------------------------------------------
// I2C sequencer step logic
// Combinational transition of the transaction state for one input beat,
// together with the result beat that the input causes.
// ----------------------------------------------------------------------------
module i2cseq_step (
  input  logic [2:0]              func,
  input  logic [6:0]              device_address,
  input  logic [7:0]              register_address,
  input  logic [7:0]              write_data,
  input  logic [2:0]              done_status,
  input  logic [7:0]              done_data,
  input  i2cseq_pkg::seq_state_t  st,
  output i2cseq_pkg::seq_state_t  st_next,
  output i2cseq_pkg::seq_result_t rslt
);
  import i2cseq_pkg::*;

  logic       ok;
  logic       is_cmd;
  logic       is_done;
  phase_t     phase_next;
  logic [7:0] addr_wr;
  logic [7:0] addr_rd;

  assign ok      = (done_status == DS_OK);
  assign is_cmd  = (func == FUNC_POLL) || (func == FUNC_READ) || (func == FUNC_WRITE);
  assign is_done = (func == FUNC_DONE) && (st.phase != PH_IDLE);
  assign addr_wr = {st.saved_device, 1'b0};
  assign addr_rd = {st.saved_device, 1'b1};

  // Next phase.
  always_comb begin
    phase_next = st.phase;
    if (is_cmd && st.phase == PH_IDLE) begin
      if (func == FUNC_POLL) begin
        phase_next = st.bus_dirty ? PH_RECOVER : PH_START;
      end else begin
        phase_next = st.bus_dirty ? PH_IDLE : PH_START;
      end
    end else if (is_done) begin
      unique case (st.phase)
        PH_RECOVER: phase_next = ok ? PH_START : PH_IDLE;
        PH_START:   phase_next = ok ? PH_ADDR : PH_IDLE;
        PH_ADDR: begin
          if (st.operation == OP_POLL) begin
            phase_next = PH_STOP;
          end else begin
            phase_next = ok ? PH_REG : PH_ERRSTOP;
          end
        end
        PH_REG: begin
          if (!ok) begin
            phase_next = PH_ERRSTOP;
          end else begin
            phase_next = (st.operation == OP_READ) ? PH_RESTART : PH_DATA;
          end
        end
        PH_RESTART: phase_next = ok ? PH_ADDR_RD : PH_ERRSTOP;
        PH_ADDR_RD: phase_next = ok ? PH_READ : PH_ERRSTOP;
        PH_READ:    phase_next = ok ? PH_STOP : PH_ERRSTOP;
        PH_DATA:    phase_next = ok ? PH_STOP : PH_ERRSTOP;
        default:    phase_next = PH_IDLE;
      endcase
    end
  end

  // Result beat and the remaining state fields.
  always_comb begin
    st_next       = st;
    st_next.phase = phase_next;
    rslt          = '0;
    rslt.kind     = KIND_IGNORE;
    if (func == FUNC_DIRTY) begin
      st_next.bus_dirty = 1'b1;
    end else if (is_cmd && st.phase == PH_IDLE) begin
      st_next.operation      = op_t'(func[1:0]);
      st_next.saved_device   = device_address;
      st_next.saved_register = register_address;
      st_next.saved_byte     = write_data;
      st_next.pending        = ST_OK;
      if (func == FUNC_POLL) begin
        rslt.kind = KIND_ISSUE;
        rslt.prim = st.bus_dirty ? PRIM_RECOVER : PRIM_START;
      end else if (st.bus_dirty) begin
        rslt.kind   = KIND_FINISH;
        rslt.status = ST_DIRTY;
      end else begin
        rslt.kind = KIND_ISSUE;
        rslt.prim = PRIM_START;
      end
    end else if (is_done) begin
      rslt.kind = KIND_ISSUE;
      unique case (st.phase)
        PH_RECOVER: begin
          if (ok) begin
            st_next.bus_dirty = 1'b0;
            rslt.prim         = PRIM_START;
          end else begin
            rslt.kind   = KIND_FINISH;
            rslt.status = ST_HWFAIL;
          end
        end
        PH_START: begin
          if (ok) begin
            rslt.prim     = PRIM_WRITE;
            rslt.byte_out = addr_wr;
          end else begin
            st_next.bus_dirty = 1'b1;
            rslt.kind         = KIND_FINISH;
            rslt.status       = ST_COMMFAIL;
          end
        end
        PH_ADDR: begin
          if (st.operation == OP_POLL) begin
            st_next.pending = ok ? POLL_ACK :
                              (done_status == DS_NAK) ? POLL_NAK : POLL_FAIL;
            rslt.prim = PRIM_STOP;
          end else if (ok) begin
            rslt.prim     = PRIM_WRITE;
            rslt.byte_out = st.saved_register;
          end else begin
            st_next.pending = (done_status == DS_NAK) ? ST_BADADDR : ST_COMMFAIL;
            rslt.prim       = PRIM_STOP;
          end
        end
        PH_REG: begin
          if (!ok) begin
            st_next.pending = ST_COMMFAIL;
            rslt.prim       = PRIM_STOP;
          end else if (st.operation == OP_READ) begin
            rslt.prim = PRIM_RESTART;
          end else begin
            rslt.prim     = PRIM_WRITE;
            rslt.byte_out = st.saved_byte;
          end
        end
        PH_RESTART: begin
          if (ok) begin
            rslt.prim     = PRIM_WRITE;
            rslt.byte_out = addr_rd;
          end else begin
            st_next.pending = ST_COMMFAIL;
            rslt.prim       = PRIM_STOP;
          end
        end
        PH_ADDR_RD: begin
          rslt.prim = ok ? PRIM_READ : PRIM_STOP;
          if (!ok) begin
            st_next.pending = ST_COMMFAIL;
          end
        end
        PH_READ: begin
          rslt.prim = PRIM_STOP;
          if (ok) begin
            // The received byte is parked here until the stop completes.
            st_next.saved_byte = done_data;
          end else begin
            st_next.pending = ST_COMMFAIL;
          end
        end
        PH_DATA: begin
          rslt.prim = PRIM_STOP;
          if (!ok) begin
            st_next.pending = ST_COMMFAIL;
          end
        end
        PH_STOP: begin
          rslt.kind = KIND_FINISH;
          if (st.operation == OP_POLL) begin
            if (ok && st.pending == POLL_ACK) begin
              rslt.status = ST_OK;
            end else if (ok && st.pending == POLL_NAK) begin
              rslt.status = ST_BADADDR;
            end else begin
              st_next.bus_dirty = 1'b1;
              rslt.status       = ST_COMMFAIL;
            end
          end else if (ok) begin
            rslt.status    = ST_OK;
            rslt.read_data = (st.operation == OP_READ) ? st.saved_byte : 8'h00;
          end else begin
            st_next.bus_dirty = 1'b1;
            rslt.status       = ST_COMMFAIL;
          end
        end
        PH_ERRSTOP: begin
          // The stop outcome is ignored; the saved error is reported.
          st_next.bus_dirty = 1'b1;
          rslt.kind         = KIND_FINISH;
          rslt.status       = st.pending;
        end
        default: begin
          rslt.kind = KIND_IGNORE;
        end
      endcase
    end
  end

endmodule
